/* rtl/stt_pkg.sv */
// Shared types, constants and byte-class helpers for the source text tokenizer.
// No dependencies; everything else in rtl/ imports this package.
package stt_pkg;

  localparam int MAX_SOURCE_BYTES = 65536;
  localparam int OFF_CAP_I = (MAX_SOURCE_BYTES - 1 > 65535) ? 65535 : MAX_SOURCE_BYTES - 1;
  localparam int LEN_CAP_I = (MAX_SOURCE_BYTES > 131071) ? 131071 : MAX_SOURCE_BYTES;
  localparam logic [15:0] OFF_CAP = 16'(OFF_CAP_I);
  localparam logic [16:0] LEN_CAP = 17'(LEN_CAP_I);

  // output queue: one byte can close up to three tokens
  localparam int QDEPTH  = 4;
  localparam int MAX_TOK = 3;
  localparam int CNT_W   = $clog2(QDEPTH + 1);

  localparam logic [2:0] KIND_END     = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_INT     = 3'd2;
  localparam logic [2:0] KIND_SPACE   = 3'd3;
  localparam logic [2:0] KIND_STRING  = 3'd4;
  localparam logic [2:0] KIND_SPECIAL = 3'd5;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [15:0] start;
    logic [16:0] length;
    logic [15:0] line;
    logic [15:0] column;
    logic [1:0]  err;
    logic        last;
  } token_t;

  function automatic logic [15:0] sat16_inc(input logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_special(input logic [7:0] b);
    return b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH ||
           b == CH_DOT || b == CH_EQUAL || b == CH_SEMI || b == CH_LPAREN ||
           b == CH_RPAREN;
  endfunction

  function automatic token_t make_tok(input logic [2:0] kind, input logic [63:0] value,
                                      input logic [15:0] start, input logic [16:0] length,
                                      input logic [15:0] line, input logic [15:0] column,
                                      input logic [1:0] err);
    token_t t;
    t.kind   = kind;
    t.value  = value;
    t.start  = start;
    t.length = length;
    t.line   = line;
    t.column = column;
    t.err    = err;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

/* rtl/stt_if.sv */
// Valid/ready channel interfaces for source bytes in and tokens out.
// Depends on stt_pkg.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       last_byte;

  modport source (output valid, output source_byte, output last_byte, input ready);
  modport sink   (input valid, input source_byte, input last_byte, output ready);
endinterface

interface stt_out_if import stt_pkg::*;;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [63:0] token_value;
  logic [15:0] token_offset;
  logic [16:0] token_length;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_value, output token_offset,
                  output token_length, output token_line, output token_column,
                  output error_code, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_value, input token_offset,
                  input token_length, input token_line, input token_column,
                  input error_code, input last_of_run, output ready);
endinterface

/* rtl/source_text_tokenizer_top.sv */
// Source text tokenizer: one source byte per request in, tokens out.
// Depends on stt_pkg and the channel interfaces in stt_if.sv.
//
//   channel   dir  handshake      payload
//   in_if     in   valid/ready    source_byte[7:0], last_byte
//   out_if    out  valid/ready    token kind/value/start/length/line/column, error, last
//   cfg       in   cfg_we         cfg_wdata = whitespace suppress flag
//
// One byte per cycle sustained while the queue has room. A byte is held in the input
// register while the lexer logic drops its 0..3 tokens into a 4-entry output queue at the
// edge that moves it on. The byte moves on only when the queue has room for three tokens
// after this cycle's pop, so a byte that closes several tokens stalls input until the sink
// drains them. Synchronous active-low reset clears position and lexer state.
module source_text_tokenizer_top import stt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  stt_in_if.sink        in_if,
  stt_out_if.source     out_if,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  logic             skip_ws_r;
  logic             vld_r;
  logic [7:0]       byte_r;
  logic             last_r;

  logic [2:0]       pkind_r, pkind_nxt;
  logic [15:0]      pstart_r, pstart_nxt;
  logic [16:0]      plen_r, plen_nxt;
  logic [15:0]      pline_r, pline_nxt;
  logic [15:0]      pcol_r, pcol_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [15:0]      off_r, off_nxt;
  logic [15:0]      line_r, line_nxt;
  logic [15:0]      col_r, col_nxt;

  token_t           q_r [QDEPTH];
  token_t           q_nxt [QDEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  token_t           new_tok [MAX_TOK];
  logic [1:0]       n_new;
  logic             pop, adv;
  logic [CNT_W-1:0] cnt_pop;

  assign pop     = (cnt_r != '0) && out_if.ready;
  assign cnt_pop = cnt_r - CNT_W'(pop);
  assign adv     = vld_r && (cnt_pop <= CNT_W'(QDEPTH - MAX_TOK));
  assign in_if.ready = !vld_r || adv;

  // lexer step for the registered byte
  always_comb begin
    token_t     cand [4];
    logic [3:0] cand_v;
    logic [15:0] col_i;
    logic [16:0] len_inc;
    logic [3:0]  digit;
    logic        ended;
    logic        cont;
    logic        emit_old;

    for (int i = 0; i < 4; i++) begin
      cand[i] = make_tok(KIND_END, '0, '0, '0, '0, '0, ERR_NONE);
    end
    cand_v   = '0;
    col_i    = sat16_inc(col_r);
    len_inc  = (plen_r < LEN_CAP) ? plen_r + 17'd1 : LEN_CAP;
    digit    = byte_r[3:0];
    ended    = 1'b0;
    emit_old = (pkind_r != KIND_END) && !(pkind_r == KIND_SPACE && skip_ws_r);
    cont     = (pkind_r == KIND_IDENT && (is_alpha(byte_r) || is_digit(byte_r))) ||
               (pkind_r == KIND_INT && is_digit(byte_r)) ||
               (pkind_r == KIND_SPACE && is_space(byte_r));

    off_nxt = (off_r < OFF_CAP) ? off_r + 16'd1 : OFF_CAP;
    if (byte_r == CH_NL) begin
      line_nxt = sat16_inc(line_r);
      col_nxt  = '0;
    end else begin
      line_nxt = line_r;
      col_nxt  = col_i;
    end

    pkind_nxt  = pkind_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    pline_nxt  = pline_r;
    pcol_nxt   = pcol_r;
    acc_nxt    = acc_r;

    if (pkind_r == KIND_STRING) begin
      plen_nxt = len_inc;
      if (byte_r == CH_QUOTE) begin
        cand[0]   = make_tok(KIND_STRING, '0, pstart_r, len_inc, pline_r, pcol_r, ERR_NONE);
        cand_v[0] = 1'b1;
        pkind_nxt = KIND_END;
        pstart_nxt = '0;
        plen_nxt  = '0;
        pline_nxt = '0;
        pcol_nxt  = '0;
        acc_nxt   = '0;
      end
    end else if (cont) begin
      if (pkind_r == KIND_INT) begin
        acc_nxt = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0} + {60'd0, digit};
      end
      plen_nxt = len_inc;
    end else begin
      cand[0]   = make_tok(pkind_r, (pkind_r == KIND_INT) ? acc_r : '0, pstart_r, plen_r,
                           pline_r, pcol_r, ERR_NONE);
      cand_v[0] = emit_old;
      pkind_nxt  = KIND_END;
      pstart_nxt = '0;
      plen_nxt   = '0;
      pline_nxt  = '0;
      pcol_nxt   = '0;
      acc_nxt    = '0;
      if (is_alpha(byte_r) || is_digit(byte_r) || is_space(byte_r) || byte_r == CH_QUOTE) begin
        pstart_nxt = off_r;
        plen_nxt   = 17'd1;
        pline_nxt  = line_r;
        pcol_nxt   = col_i;
        priority if (is_alpha(byte_r)) begin
          pkind_nxt = KIND_IDENT;
        end else if (is_digit(byte_r)) begin
          pkind_nxt = KIND_INT;
          acc_nxt   = {60'd0, digit};
        end else if (is_space(byte_r)) begin
          pkind_nxt = KIND_SPACE;
        end else begin
          pkind_nxt = KIND_STRING;
        end
      end else if (is_special(byte_r)) begin
        cand[1]   = make_tok(KIND_SPECIAL, {56'd0, byte_r}, off_r, 17'd1, line_r, col_i,
                             ERR_NONE);
        cand_v[1] = 1'b1;
      end else begin
        cand[1]   = make_tok(KIND_END, {56'd0, byte_r}, off_r, '0, line_r, col_i,
                             (byte_r != CH_NUL) ? ERR_UNKNOWN : ERR_NONE);
        cand_v[1] = 1'b1;
        ended     = 1'b1;
      end
    end

    if (!ended && last_r) begin
      if (pkind_nxt == KIND_STRING) begin
        cand[3] = make_tok(KIND_END, '0, pstart_nxt, plen_nxt, pline_nxt, pcol_nxt,
                           ERR_UNTERM);
      end else begin
        cand[2]   = make_tok(pkind_nxt, (pkind_nxt == KIND_INT) ? acc_nxt : '0, pstart_nxt,
                             plen_nxt, pline_nxt, pcol_nxt, ERR_NONE);
        cand_v[2] = (pkind_nxt != KIND_END) && !(pkind_nxt == KIND_SPACE && skip_ws_r);
        cand[3]   = make_tok(KIND_END, '0, off_nxt, '0, line_nxt, sat16_inc(col_nxt),
                             ERR_NONE);
      end
      cand_v[3] = 1'b1;
      ended     = 1'b1;
    end

    // end of source: start the next one from offset 0
    if (ended) begin
      pkind_nxt  = KIND_END;
      pstart_nxt = '0;
      plen_nxt   = '0;
      pline_nxt  = '0;
      pcol_nxt   = '0;
      acc_nxt    = '0;
      off_nxt    = '0;
      line_nxt   = '0;
      col_nxt    = '0;
    end

    // pack the emitted candidates in order; at most three are ever valid
    for (int j = 0; j < MAX_TOK; j++) begin
      new_tok[j] = cand[0];
    end
    n_new = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && n_new != 2'(MAX_TOK)) begin
        new_tok[n_new] = cand[i];
        n_new = n_new + 2'd1;
      end
    end
    if (n_new != '0) begin
      new_tok[n_new - 2'd1].last = 1'b1;
    end
  end

  // output queue: entry 0 is the head, shifts down on pop
  always_comb begin
    logic [CNT_W-1:0] idx;
    for (int i = 0; i < QDEPTH; i++) begin
      idx = CNT_W'(i) - cnt_pop;
      if (pop && i + 1 < QDEPTH) begin
        q_nxt[i] = q_r[(i + 1) % QDEPTH];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (adv && CNT_W'(i) >= cnt_pop && idx < CNT_W'(n_new)) begin
        q_nxt[i] = new_tok[idx[1:0]];
      end
    end
    cnt_nxt = cnt_pop + (adv ? CNT_W'(n_new) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_ws_r <= 1'b0;
      vld_r     <= 1'b0;
      cnt_r     <= '0;
      pkind_r   <= KIND_END;
      pstart_r  <= '0;
      plen_r    <= '0;
      pline_r   <= '0;
      pcol_r    <= '0;
      acc_r     <= '0;
      off_r     <= '0;
      line_r    <= '0;
      col_r     <= '0;
    end else begin
      if (cfg_we) begin
        skip_ws_r <= cfg_wdata;
      end
      if (in_if.ready) begin
        vld_r <= in_if.valid;
      end
      cnt_r <= cnt_nxt;
      if (adv) begin
        pkind_r  <= pkind_nxt;
        pstart_r <= pstart_nxt;
        plen_r   <= plen_nxt;
        pline_r  <= pline_nxt;
        pcol_r   <= pcol_nxt;
        acc_r    <= acc_nxt;
        off_r    <= off_nxt;
        line_r   <= line_nxt;
        col_r    <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      byte_r <= in_if.source_byte;
      last_r <= in_if.last_byte;
    end
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_if.valid        = (cnt_r != '0);
  assign out_if.token_kind   = q_r[0].kind;
  assign out_if.token_value  = q_r[0].value;
  assign out_if.token_offset = q_r[0].start;
  assign out_if.token_length = q_r[0].length;
  assign out_if.token_line   = q_r[0].line;
  assign out_if.token_column = q_r[0].column;
  assign out_if.error_code   = q_r[0].err;
  assign out_if.last_of_run  = q_r[0].last;

endmodule
